### rtl/swap_slot_refcount_allocator_defines.svh
// ----------------------------------------------------------------------------
// Swap slot allocator assertion macros
// Shared property macros for the swap slot reference-count allocator.
// ----------------------------------------------------------------------------
`ifndef SWAP_SLOT_REFCOUNT_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_REFCOUNT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SSRA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SSRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssra_pkg.sv
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Types and fixed constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package ssra_pkg;

  // Field widths fixed by the interface.
  localparam int SLOT_W      = 10;
  localparam int CMD_W       = 2;
  localparam int CNT_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + CNT_W + 2 + STATUS_W);

  // Table entry value that marks a slot as unused.
  localparam logic [CNT_W-1:0] UNUSED_MARK = '1;

  // Smallest effective slot limit and the limit after reset.
  localparam int               LIMIT_MIN   = 512;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_ADD_REF  = 2'd1,
    CMD_TRY_FREE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_BAD_SLOT   = 2'd2,
    ST_REFERENCED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_e;

  // Classified request as it waits in the queue.
  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic [CNT_W-1:0]  ref_count;
    logic              slot_unused;
    logic              reclaimed;
    status_e           status;
  } res_t;

endpackage

### rtl/swap_slot_refcount_allocator.sv
// ----------------------------------------------------------------------------
// Swap slot reference-count allocator
// Next-fit swap slot allocator with a 16-bit reference count per slot.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (tuser: command, tdata: slot) and each
// gives exactly one result on the m_axis channel. The cfg channel writes the
// slot limit; write it only while no request is outstanding.
// After reset the block sweeps all SLOTS entries of the slot table (1024 by
// default), one entry per cycle; s_axis_tready_o stays low during that sweep
// while configuration writes are still taken.
// Add-reference, free and query requests read their entry, then update it and
// build the result in S_EXEC and hand it to the output register in S_RESP.
// An allocate walks the table through its single read port, one slot per
// cycle; the worst case is a full pass over slots 1 to limit - 1. One request is
// worked on at a time: the back end takes no new one until the last is done.
// A two-entry request queue lets the sender run ahead while a request is
// being worked on. Results wait in an output register: when the receiver
// holds m_axis_tready_i low, finished work stops in front of that register
// and the queue fills, after which s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`include "swap_slot_refcount_allocator_defines.svh"

module swap_slot_refcount_allocator #(
  parameter int SLOTS   = 1024,
  parameter int MAX_REF = 32767
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write: slot limit.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ssra_pkg::CFG_W-1:0]         cfg_data_i,
  // Request stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: slot [9:0], zero padding [15:10].
  input  logic [ssra_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser: cmd [1:0].
  input  logic [ssra_pkg::CMD_W-1:0]         s_axis_tuser_i,
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: result_slot [9:0], ref_count [25:10], slot_unused [26],
  // reclaimed [27], status [29:28], zero padding [31:30].
  output logic [ssra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  logic [ssra_pkg::CFG_W-1:0] slot_limit_q;
  logic                       q_valid, q_ready, clearing;
  ssra_pkg::req_t             q_req;
  ssra_pkg::res_t             m_res;

  // Slot limit register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= ssra_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slot_limit_q <= cfg_data_i;
    end
  end

  ssra_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_en_i (!clearing),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_cmd_i     (ssra_pkg::cmd_e'(s_axis_tuser_i)),
    .s_slot_i    (s_axis_tdata_i[ssra_pkg::SLOT_W-1:0]),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_req_o     (q_req)
  );

  ssra_back #(
    .SLOTS   (SLOTS),
    .MAX_REF (MAX_REF)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_limit_i (slot_limit_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_req_i      (q_req),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_res_o      (m_res),
    .clearing_o   (clearing)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_axis_tdata_o = {{ssra_pkg::OUT_PAD_W{1'b0}}, m_res.status, m_res.reclaimed,
                           m_res.slot_unused, m_res.ref_count, m_res.result_slot};

  // No request may enter while the table sweep is still running.
  `SSRA_ASSERT_IMPLIES(a_no_accept_in_clear, clearing, !(s_axis_tvalid_i && s_axis_tready_o), "request accepted during table sweep")

  // A failed allocation reports slot 0 and no reclaim.
  `SSRA_ASSERT_IMPLIES(a_fail_slot_zero, m_axis_tvalid_o && m_res.status == ssra_pkg::ST_NO_FREE, m_res.result_slot == '0 && !m_res.reclaimed, "failed allocation carries a slot")

  // A reclaim hands out a real slot with a zero count.
  `SSRA_ASSERT_IMPLIES(a_reclaim_ok, m_axis_tvalid_o && m_res.reclaimed, m_res.status == ssra_pkg::ST_OK && m_res.result_slot != '0 && m_res.ref_count == '0 && !m_res.slot_unused, "bad reclaim result")

endmodule

### rtl/ssra_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ssra_front.sv
// ----------------------------------------------------------------------------
// Swap slot allocator front end
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ssra_front #(
  parameter int SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_en_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  ssra_pkg::cmd_e                s_cmd_i,
  input  logic [ssra_pkg::SLOT_W-1:0]   s_slot_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output ssra_pkg::req_t                q_req_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = (SW + 1 > ssra_pkg::SLOT_W + 1) ? SW + 1 : ssra_pkg::SLOT_W + 1;

  ssra_pkg::req_t entry_q [2];
  ssra_pkg::req_t new_req;
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  // Classify the incoming request: mark slot indices past the table.
  always_comb begin
    new_req.cmd      = s_cmd_i;
    new_req.slot     = s_slot_i;
    new_req.in_range = LW'(s_slot_i) < LW'(SLOTS);
  end

  assign s_ready_o = (cnt_q != 2'd2) && accept_en_i;
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_req_o   = entry_q[rp_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wp_q] <= new_req;
    end
  end

endmodule

### rtl/ssra_back.sv
// ----------------------------------------------------------------------------
// Swap slot allocator back end
// Runs queued requests against the slot table: next-fit scan and updates.
// ----------------------------------------------------------------------------
module ssra_back #(
  parameter int SLOTS   = 1024,
  parameter int MAX_REF = 32767
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ssra_pkg::CFG_W-1:0]  slot_limit_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  ssra_pkg::req_t              q_req_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output ssra_pkg::res_t              m_res_o,
  output logic                        clearing_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = (SW + 1 > ssra_pkg::CFG_W) ? SW + 1 : ssra_pkg::CFG_W;
  localparam int CW = ssra_pkg::CNT_W;

  ssra_pkg::state_e state_q, state_d;
  ssra_pkg::req_t   cur_q, cur_d;
  ssra_pkg::res_t   res_q, res_d, out_q, out_d;
  logic                        out_v_q, out_v_d;
  logic [SW-1:0]               iss_p_q, iss_p_d;
  logic [SW-1:0]               iss_n_q, iss_n_d;
  logic                        eval_v_q, eval_v_d;
  logic [SW-1:0]               eval_a_q, eval_a_d;
  logic [SW-1:0]               zero_q, zero_d;
  logic [ssra_pkg::SLOT_W-1:0] ptr_q, ptr_d;
  logic [SW-1:0]               clr_q, clr_d;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  logic [LW-1:0] cfg_ext, lim, lim_m1, ptr_ext;
  logic [SW-1:0] scan_start, found_next, scan_tgt;
  logic          rd_unused, rd_zero, iss_done, scan_found, scan_end;

  logic [CW-1:0]     exec_v, exec_new;
  logic              exec_we;
  ssra_pkg::status_e exec_st;

  logic out_load;

  // Slot after a, wrapping back to slot 1 at the limit.
  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] a,
                                              input logic [LW-1:0] l);
    logic [LW-1:0] s;
    s = LW'(a) + LW'(1);
    if (s >= l) begin
      return SW'(1);
    end
    return SW'(s);
  endfunction

  ssra_ram #(
    .WIDTH (CW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective limit, saturated to LIMIT_MIN .. SLOTS, and the scan start.
  always_comb begin
    cfg_ext = LW'(slot_limit_i);
    if (cfg_ext < LW'(ssra_pkg::LIMIT_MIN)) begin
      lim = LW'(ssra_pkg::LIMIT_MIN);
    end else if (cfg_ext > LW'(SLOTS)) begin
      lim = LW'(SLOTS);
    end else begin
      lim = cfg_ext;
    end
    lim_m1  = lim - LW'(1);
    ptr_ext = LW'(ptr_q);
    if (ptr_q == '0 || ptr_ext >= lim) begin
      scan_start = SW'(1);
    end else begin
      scan_start = SW'(ptr_q);
    end
  end

  // Scan evaluation of the entry read in the previous cycle.
  always_comb begin
    rd_unused  = (ram_rdata == ssra_pkg::UNUSED_MARK);
    rd_zero    = (ram_rdata == '0);
    iss_done   = (LW'(iss_n_q) == lim_m1);
    scan_found = eval_v_q && rd_unused;
    scan_end   = eval_v_q && iss_done && !rd_unused;
    found_next = next_slot(eval_a_q, lim);
    if (zero_q != '0) begin
      scan_tgt = zero_q;
    end else if (rd_zero) begin
      scan_tgt = eval_a_q;
    end else begin
      scan_tgt = '0;
    end
  end

  // Add-reference, free and query against the entry just read.
  always_comb begin
    exec_v   = cur_q.in_range ? ram_rdata : ssra_pkg::UNUSED_MARK;
    exec_new = exec_v;
    exec_we  = 1'b0;
    exec_st  = ssra_pkg::ST_OK;
    case (cur_q.cmd)
      ssra_pkg::CMD_ADD_REF: begin
        if (exec_v == ssra_pkg::UNUSED_MARK || exec_v >= CW'(MAX_REF) ||
            !cur_q.in_range) begin
          exec_st = ssra_pkg::ST_BAD_SLOT;
        end else begin
          exec_new = exec_v + CW'(1);
          exec_we  = 1'b1;
        end
      end
      ssra_pkg::CMD_TRY_FREE: begin
        if (exec_v == ssra_pkg::UNUSED_MARK) begin
          exec_st = ssra_pkg::ST_BAD_SLOT;
        end else if (exec_v != '0) begin
          exec_st = ssra_pkg::ST_REFERENCED;
        end else if (cur_q.in_range) begin
          exec_new = ssra_pkg::UNUSED_MARK;
          exec_we  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next state, table accesses and result assembly.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    res_d     = res_q;
    iss_p_d   = iss_p_q;
    iss_n_d   = iss_n_q;
    eval_v_d  = 1'b0;
    eval_a_d  = eval_a_q;
    zero_d    = zero_q;
    ptr_d     = ptr_q;
    clr_d     = clr_q;
    q_ready_o = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = iss_p_q;
    ram_we    = 1'b0;
    ram_waddr = eval_a_q;
    ram_wdata = ssra_pkg::UNUSED_MARK;
    out_load  = 1'b0;

    case (state_q)
      // Sweep the table after reset, marking every slot unused.
      ssra_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + SW'(1);
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = ssra_pkg::S_IDLE;
        end
      end

      // Take the next request from the queue.
      ssra_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_ready_o = 1'b1;
          cur_d     = q_req_i;
          if (q_req_i.cmd == ssra_pkg::CMD_ALLOC) begin
            iss_p_d = scan_start;
            iss_n_d = '0;
            zero_d  = '0;
            state_d = ssra_pkg::S_SCAN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = SW'(q_req_i.slot);
            state_d   = ssra_pkg::S_EXEC;
          end
        end
      end

      // Single-entry command: update the entry and build the result.
      ssra_pkg::S_EXEC: begin
        ram_we    = exec_we;
        ram_waddr = SW'(cur_q.slot);
        ram_wdata = exec_new;
        res_d.result_slot = cur_q.slot;
        res_d.reclaimed   = 1'b0;
        res_d.status      = exec_st;
        if (exec_new == ssra_pkg::UNUSED_MARK) begin
          res_d.slot_unused = 1'b1;
          res_d.ref_count   = '0;
        end else begin
          res_d.slot_unused = 1'b0;
          res_d.ref_count   = exec_new;
        end
        state_d = ssra_pkg::S_RESP;
      end

      // Next-fit scan: one read issued per cycle, each checked in the cycle after its read.
      ssra_pkg::S_SCAN: begin
        res_d.ref_count   = '0;
        res_d.slot_unused = 1'b0;
        res_d.reclaimed   = 1'b0;
        res_d.status      = ssra_pkg::ST_OK;
        res_d.result_slot = '0;
        if (eval_v_q && rd_zero && zero_q == '0) begin
          zero_d = eval_a_q;
        end
        if (scan_found) begin
          ram_we            = 1'b1;
          ram_waddr         = eval_a_q;
          ram_wdata         = '0;
          res_d.result_slot = ssra_pkg::SLOT_W'(eval_a_q);
          ptr_d             = ssra_pkg::SLOT_W'(found_next);
          state_d           = ssra_pkg::S_RESP;
        end else if (scan_end) begin
          // Full pass made: the issue pointer is back at its start.
          ptr_d = ssra_pkg::SLOT_W'(iss_p_q);
          if (scan_tgt != '0) begin
            ram_we            = 1'b1;
            ram_waddr         = scan_tgt;
            ram_wdata         = '0;
            res_d.result_slot = ssra_pkg::SLOT_W'(scan_tgt);
            res_d.reclaimed   = 1'b1;
          end else begin
            res_d.status = ssra_pkg::ST_NO_FREE;
          end
          state_d = ssra_pkg::S_RESP;
        end else if (!iss_done) begin
          ram_re    = 1'b1;
          ram_raddr = iss_p_q;
          iss_p_d   = next_slot(iss_p_q, lim);
          iss_n_d   = iss_n_q + SW'(1);
          eval_v_d  = 1'b1;
          eval_a_d  = iss_p_q;
        end
      end

      // Hand the result to the output register once it has room.
      ssra_pkg::S_RESP: begin
        if (!out_v_q || m_ready_i) begin
          out_load = 1'b1;
          state_d  = ssra_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ssra_pkg::S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_d = out_load ? res_q : out_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (m_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssra_pkg::S_CLEAR;
      clr_q    <= '0;
      ptr_q    <= ssra_pkg::SLOT_W'(1);
      eval_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ptr_q    <= ptr_d;
      eval_v_q <= eval_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    res_q    <= res_d;
    out_q    <= out_d;
    iss_p_q  <= iss_p_d;
    iss_n_q  <= iss_n_d;
    eval_a_q <= eval_a_d;
    zero_q   <= zero_d;
  end

  assign m_valid_o  = out_v_q;
  assign m_res_o    = out_q;
  assign clearing_o = (state_q == ssra_pkg::S_CLEAR);

endmodule

### sim/tb_swap_slot_refcount_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swap slot allocator testbench
// Drives allocate, add-reference, free and query requests into the swap slot
// allocator under several slot limits and idle/stall mixes. A local model of
// the count table and the next-fit pointer predicts every result, and a
// monitor compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_swap_slot_refcount_allocator;

  localparam int TABLE_DEPTH    = 1024;
  localparam int COUNT_MAX      = 32767;
  localparam int COUNT_STEPS    = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_DRAIN      = 1100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [ssra_pkg::CFG_W-1:0]       cfg_data_i = '0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  // tdata: slot [9:0], zero padding [15:10].
  logic [ssra_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  // tuser: cmd [1:0].
  logic [ssra_pkg::CMD_W-1:0]       s_axis_tuser_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  // tdata: result_slot [9:0], ref_count [25:10], slot_unused [26],
  // reclaimed [27], status [29:28], zero padding [31:30].
  logic [ssra_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Model of the block: count table, next-fit pointer and slot limit.
  logic [ssra_pkg::CNT_W-1:0]  slot_counts [TABLE_DEPTH];
  logic [ssra_pkg::SLOT_W-1:0] scan_pointer;
  logic [ssra_pkg::CFG_W-1:0]  slot_limit;

  ssra_pkg::res_t              pending_slot_results [$];
  logic [ssra_pkg::SLOT_W-1:0] owned_slots [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int error_count     = 0;
  int stall_cycles    = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int allocs_granted  = 0;
  int allocs_reclaimed = 0;
  int allocs_refused  = 0;
  int requests_rejected = 0;
  int limits_written  = 0;

  swap_slot_refcount_allocator #(
    .SLOTS  (TABLE_DEPTH),
    .MAX_REF(COUNT_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // The slot limit saturates to the range the table supports.
  function automatic int unsigned effective_limit();
    int unsigned lim;
    lim = slot_limit;
    if (lim < ssra_pkg::LIMIT_MIN) lim = ssra_pkg::LIMIT_MIN;
    if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
    return lim;
  endfunction

  // Applies one request to the model and returns the result it must give.
  function automatic ssra_pkg::res_t predict_slot_result(ssra_pkg::cmd_e cmd,
                                                         logic [ssra_pkg::SLOT_W-1:0] slot);
    ssra_pkg::res_t             r;
    int unsigned                lim, p, cur, n, free_slot, zero_slot;
    logic [ssra_pkg::CNT_W-1:0] v;
    r.result_slot = slot;
    r.ref_count   = '0;
    r.slot_unused = 1'b0;
    r.reclaimed   = 1'b0;
    r.status      = ssra_pkg::ST_OK;
    if (cmd == ssra_pkg::CMD_ALLOC) begin
      lim = effective_limit();
      p = scan_pointer;
      if (p == 0 || p >= lim) p = 1;
      free_slot = 0;
      zero_slot = 0;
      // Next-fit walk: first unused slot wins, else the first zero count.
      for (n = 0; n + 1 < lim; n++) begin
        cur = p;
        v = slot_counts[cur];
        p++;
        if (p >= lim) p = 1;
        if (v == ssra_pkg::UNUSED_MARK) begin
          free_slot = cur;
          break;
        end
        if (v == '0 && zero_slot == 0) zero_slot = cur;
      end
      scan_pointer = p[ssra_pkg::SLOT_W-1:0];
      if (free_slot != 0) begin
        slot_counts[free_slot] = '0;
        r.result_slot = free_slot[ssra_pkg::SLOT_W-1:0];
        allocs_granted++;
      end else if (zero_slot != 0) begin
        slot_counts[zero_slot] = '0;
        r.result_slot = zero_slot[ssra_pkg::SLOT_W-1:0];
        r.reclaimed = 1'b1;
        allocs_reclaimed++;
      end else begin
        r.result_slot = '0;
        r.status = ssra_pkg::ST_NO_FREE;
        allocs_refused++;
      end
    end else begin
      v = slot_counts[slot];
      if (cmd == ssra_pkg::CMD_ADD_REF) begin
        if (v == ssra_pkg::UNUSED_MARK || v >= COUNT_MAX) begin
          r.status = ssra_pkg::ST_BAD_SLOT;
        end else begin
          v = v + 1'b1;
          slot_counts[slot] = v;
        end
      end else if (cmd == ssra_pkg::CMD_TRY_FREE) begin
        if (v == ssra_pkg::UNUSED_MARK) begin
          r.status = ssra_pkg::ST_BAD_SLOT;
        end else if (v != '0) begin
          r.status = ssra_pkg::ST_REFERENCED;
        end else begin
          v = ssra_pkg::UNUSED_MARK;
          slot_counts[slot] = v;
        end
      end
      if (r.status != ssra_pkg::ST_OK) requests_rejected++;
      if (v == ssra_pkg::UNUSED_MARK) r.slot_unused = 1'b1;
      else r.ref_count = v;
    end
    return r;
  endfunction

  // Sends one request, with random gaps, and records its expected result.
  task automatic send_request(input ssra_pkg::cmd_e cmd,
                              input logic [ssra_pkg::SLOT_W-1:0] slot,
                              output ssra_pkg::res_t predicted);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(ssra_pkg::IN_TDATA_W-ssra_pkg::SLOT_W){1'b0}}, slot};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_slot_result(cmd, slot);
    pending_slot_results.push_back(predicted);
    requests_sent++;
    if (cmd == ssra_pkg::CMD_ALLOC && predicted.status == ssra_pkg::ST_OK) begin
      owned_slots.push_back(predicted.result_slot);
    end
  endtask

  // Holds the request stream off until every outstanding result is back.
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_slot_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_limit(input logic [ssra_pkg::CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slot_limit = value;
    limits_written++;
  endtask

  // Every command once, the reserved slot, and the field extremes.
  task automatic test_command_basics();
    ssra_pkg::res_t r;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_request(ssra_pkg::CMD_QUERY,    10'd0,    r);
    send_request(ssra_pkg::CMD_ADD_REF,  10'd0,    r);
    send_request(ssra_pkg::CMD_TRY_FREE, 10'd0,    r);
    send_request(ssra_pkg::CMD_QUERY,    10'h3FF,  r);
    send_request(ssra_pkg::CMD_ALLOC,    10'd0,    r);
    send_request(ssra_pkg::CMD_ALLOC,    10'h3FF,  r);
    send_request(ssra_pkg::CMD_ADD_REF,  10'd1,    r);
    send_request(ssra_pkg::CMD_TRY_FREE, 10'd1,    r);
    send_request(ssra_pkg::CMD_QUERY,    10'd1,    r);
    send_request(ssra_pkg::CMD_TRY_FREE, 10'd2,    r);
    send_request(ssra_pkg::CMD_TRY_FREE, 10'd2,    r);
    send_request(ssra_pkg::CMD_ADD_REF,  10'd2,    r);
    send_request(ssra_pkg::CMD_ALLOC,    10'h2AA,  r);
    send_request(ssra_pkg::CMD_ADD_REF,  10'h3FF,  r);
    send_request(ssra_pkg::CMD_QUERY,    10'h2AA,  r);
    send_request(ssra_pkg::CMD_QUERY,    10'h155,  r);
    send_request(ssra_pkg::CMD_TRY_FREE, 10'h200,  r);
    send_request(ssra_pkg::CMD_ALLOC,    10'h155,  r);
    wait_for_results();
  endtask

  // Builds one count up back to back, then reads it and tries to free it.
  task automatic test_count_steps();
    ssra_pkg::res_t              r;
    logic [ssra_pkg::SLOT_W-1:0] target;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_request(ssra_pkg::CMD_ALLOC, 10'd0, r);
    target = r.result_slot;
    repeat (COUNT_STEPS) send_request(ssra_pkg::CMD_ADD_REF, target, r);
    send_request(ssra_pkg::CMD_QUERY,    target, r);
    send_request(ssra_pkg::CMD_TRY_FREE, target, r);
    wait_for_results();
  endtask

  // Mostly well-formed traffic on slots already handed out, plus noise.
  task automatic test_mixed_traffic(input logic [ssra_pkg::CFG_W-1:0] limit,
                                    input int send_pct, input int recv_pct,
                                    input int count);
    ssra_pkg::res_t              r;
    int                          pick;
    ssra_pkg::cmd_e              cmd;
    logic [ssra_pkg::SLOT_W-1:0] slot;
    wait_for_results();
    write_slot_limit(limit);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      slot = ssra_pkg::SLOT_W'($urandom_range(TABLE_DEPTH - 1));
      if (pick < 28) begin
        cmd = ssra_pkg::CMD_ALLOC;
      end else if (pick < 85) begin
        cmd = (pick < 55) ? ssra_pkg::CMD_ADD_REF :
              (pick < 72) ? ssra_pkg::CMD_TRY_FREE : ssra_pkg::CMD_QUERY;
        if (owned_slots.size() != 0) begin
          slot = owned_slots[$urandom_range(owned_slots.size() - 1)];
        end
      end else begin
        cmd = ssra_pkg::cmd_e'($urandom_range(3));
      end
      send_request(cmd, slot, r);
      // Let the block run completely dry once in the middle of the phase.
      if (i == count / 2) wait_for_results();
    end
    wait_for_results();
  endtask

  // Pointer beyond a lowered limit, a full table and zero-count reclaim.
  task automatic test_scan_exhaustion();
    ssra_pkg::res_t r;
    int             guard;
    bit             found;
    sender_idle_pct = 0;
    recv_stall_pct  = 19;
    wait_for_results();
    write_slot_limit(11'h7FF);
    guard = 0;
    while (scan_pointer < ssra_pkg::LIMIT_MIN && guard < TABLE_DEPTH) begin
      send_request(ssra_pkg::CMD_ALLOC, 10'd0, r);
      guard++;
    end
    wait_for_results();
    // The pointer now sits at or above the smallest limit, so the scan
    // restarts at slot 1.
    write_slot_limit(11'd0);
    for (guard = 0; guard < TABLE_DEPTH; guard++) begin
      found = 1'b0;
      for (int s = 1; s < effective_limit(); s++) begin
        if (slot_counts[s] == ssra_pkg::UNUSED_MARK) found = 1'b1;
      end
      if (!found) break;
      send_request(ssra_pkg::CMD_ALLOC, 10'd0, r);
    end
    // No unused slot is left: these take back zero-count slots.
    repeat (2) send_request(ssra_pkg::CMD_ALLOC, 10'd0, r);
    wait_for_results();
    write_slot_limit(11'd1024);
    repeat (6) send_request(ssra_pkg::CMD_ALLOC, 10'd0, r);
    wait_for_results();
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    ssra_pkg::res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.result_slot = m_axis_tdata_o[9:0];
      got.ref_count   = m_axis_tdata_o[25:10];
      got.slot_unused = m_axis_tdata_o[26];
      got.reclaimed   = m_axis_tdata_o[27];
      got.status      = ssra_pkg::status_e'(m_axis_tdata_o[29:28]);
      if (pending_slot_results.size() == 0) begin
        $display("%0t: result with no request outstanding: slot=%0d count=%0d",
                 $time, got.result_slot, got.ref_count);
        $display("%0t:   unused=%0b reclaimed=%0b status=%0d",
                 $time, got.slot_unused, got.reclaimed, got.status);
        error_count++;
      end else begin
        want = pending_slot_results.pop_front();
        results_checked++;
        if (got.result_slot !== want.result_slot || got.ref_count !== want.ref_count ||
            got.slot_unused !== want.slot_unused || got.reclaimed !== want.reclaimed ||
            got.status !== want.status) begin
          $display("%0t: mismatch: expected slot=%0d count=%0d unused=%0b reclaimed=%0b %s%0d",
                   $time, want.result_slot, want.ref_count, want.slot_unused,
                   want.reclaimed, "status=", want.status);
          $display("%0t:           actual slot=%0d count=%0d unused=%0b reclaimed=%0b %s%0d",
                   $time, got.result_slot, got.ref_count, got.slot_unused,
                   got.reclaimed, "status=", got.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no request, result or write moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("swap_slot_refcount_allocator verification failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < TABLE_DEPTH; s++) slot_counts[s] = ssra_pkg::UNUSED_MARK;
    scan_pointer = 10'd1;
    slot_limit   = ssra_pkg::LIMIT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_basics();
    test_count_steps();
    test_mixed_traffic(11'd512,  0,  0,  20);
    test_mixed_traffic(11'd1023, 76, 0,  20);
    test_mixed_traffic(11'd700,  0,  76, 20);
    test_mixed_traffic(11'd1024, 19, 19, 20);
    test_scan_exhaustion();

    wait_for_results();
    repeat (END_DRAIN) @(posedge clk_i);
    if (pending_slot_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               pending_slot_results.size());
      error_count++;
    end
    $display("Run covered %0d requests and %0d results under %0d slot limit writes.",
             requests_sent, results_checked, limits_written);
    $display("Allocations: %0d fresh, %0d reclaimed, %0d refused; %0d commands rejected.",
             allocs_granted, allocs_reclaimed, allocs_refused, requests_rejected);
    if (error_count == 0) begin
      $display("swap_slot_refcount_allocator verification clean");
    end else begin
      $display("swap_slot_refcount_allocator verification failed");
    end
    $finish;
  end

endmodule
